@@ design/mspi_pkg.sv @@
package mspi_pkg;

  localparam int SPEED_WIDTH   = 24;
  localparam int CURRENT_WIDTH = 16;
  localparam int GAIN_WIDTH    = 16;
  localparam int COUNT_WIDTH   = 16;

  localparam int SPEED_FRAC    = 8;
  // 0.5 eHz and 5 eHz in raw Q.8 speed units
  localparam int ENTER_RAW     = 1 << (SPEED_FRAC - 1);
  localparam int BREAKAWAY_RAW = 5 << SPEED_FRAC;
  // leave when 5 * |speed| < 1 eHz, i.e. below 0.2 eHz
  localparam int LEAVE_MUL     = 5;
  localparam int LEAVE_LIMIT   = 1 << SPEED_FRAC;

  localparam int P_SHIFT = 12;
  localparam int I_SHIFT = 16;

  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 5;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ALIGN = 2'd1,
    PH_START = 2'd2,
    PH_LOOP  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEG_GAIN_DT = 3'd1,
    REG_IQ_UPPER      = 3'd2,
    REG_IQ_LOWER      = 3'd3,
    REG_START_MAG     = 3'd4,
    REG_ALIGN_CUR     = 3'd5,
    REG_ALIGN_TICKS   = 3'd6,
    REG_MOTION_EPS    = 3'd7
  } reg_index_t;

endpackage

@@ design/motor_speed_pi_startup_sequencer.sv @@
// Speed PI controller with align and torque-start sequencing. One control tick
// is taken per clock cycle when the result side keeps up; a tick waits in the
// input register until the result register can take it, then the PI arithmetic
// and phase update run in one combinational pass into the result register. That
// single pass, with its two gain multiplies and clamps, sets the cycle time. The
// result holds the q and d current requests and the phase after the tick.
// Configuration registers sit on the APB port at byte offsets 4*i and should be
// written only while no tick is in flight.
module motor_speed_pi_startup_sequencer
  import mspi_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             run,
  input  logic                             position_mode,
  input  logic signed [SPEED_WIDTH-1:0]    speed_request,
  input  logic signed [SPEED_WIDTH-1:0]    speed_measured,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [CURRENT_WIDTH-1:0]  iq_request,
  output logic signed [CURRENT_WIDTH-1:0]  id_request,
  output logic [1:0]                       ctrl_phase,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [APB_ADDR_WIDTH-1:0]        paddr,
  input  logic [APB_DATA_WIDTH-1:0]        pwdata,
  output logic [APB_DATA_WIDTH-1:0]        prdata,
  output logic                             pready
);

  localparam int ERR_W  = SPEED_WIDTH + 1;
  localparam int PROD_W = ERR_W + GAIN_WIDTH + 1;
  localparam int P_W    = PROD_W - P_SHIFT;
  localparam int I_W    = PROD_W - I_SHIFT;
  localparam int SUM_W  = P_W + 1;
  localparam int LOW_W  = SPEED_WIDTH + 3;

  // configuration registers
  logic [GAIN_WIDTH-1:0]           prop_gain;
  logic [GAIN_WIDTH-1:0]           integ_gain_dt;
  logic [CURRENT_WIDTH-2:0]        iq_upper;
  logic signed [CURRENT_WIDTH-1:0] iq_lower;
  logic [CURRENT_WIDTH-2:0]        start_mag;
  logic signed [CURRENT_WIDTH-1:0] align_cur;
  logic [COUNT_WIDTH-1:0]          align_ticks;
  logic [SPEED_WIDTH-2:0]          motion_eps;

  // input register
  logic                          s1_valid;
  logic                          s1_run;
  logic                          s1_pos;
  logic signed [SPEED_WIDTH-1:0] s1_req;
  logic signed [SPEED_WIDTH-1:0] s1_meas;

  // controller state, also the result payload
  phase_t                          phase, phase_next;
  logic [COUNT_WIDTH-1:0]          align_count, align_count_next;
  logic signed [CURRENT_WIDTH-1:0] integrator, integrator_next;
  logic signed [CURRENT_WIDTH-1:0] iq_held, iq_held_next;
  logic signed [CURRENT_WIDTH-1:0] id_held, id_held_next;

  logic advance;
  logic cfg_write;

  // ---------------------------------------------------------------- APB port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      integ_gain_dt <= '0;
      iq_upper      <= '0;
      iq_lower      <= '0;
      start_mag     <= '0;
      align_cur     <= '0;
      align_ticks   <= '0;
      motion_eps    <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]))
        REG_PROP_GAIN:     prop_gain     <= pwdata[GAIN_WIDTH-1:0];
        REG_INTEG_GAIN_DT: integ_gain_dt <= pwdata[GAIN_WIDTH-1:0];
        REG_IQ_UPPER:      iq_upper      <= pwdata[CURRENT_WIDTH-2:0];
        REG_IQ_LOWER:      iq_lower      <= $signed(pwdata[CURRENT_WIDTH-1:0]);
        REG_START_MAG:     start_mag     <= pwdata[CURRENT_WIDTH-2:0];
        REG_ALIGN_CUR:     align_cur     <= $signed(pwdata[CURRENT_WIDTH-1:0]);
        REG_ALIGN_TICKS:   align_ticks   <= pwdata[COUNT_WIDTH-1:0];
        REG_MOTION_EPS:    motion_eps    <= pwdata[SPEED_WIDTH-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[APB_ADDR_WIDTH-1:2]))
      REG_PROP_GAIN:     prdata = APB_DATA_WIDTH'(prop_gain);
      REG_INTEG_GAIN_DT: prdata = APB_DATA_WIDTH'(integ_gain_dt);
      REG_IQ_UPPER:      prdata = APB_DATA_WIDTH'(iq_upper);
      REG_IQ_LOWER:      prdata = APB_DATA_WIDTH'($unsigned(iq_lower));
      REG_START_MAG:     prdata = APB_DATA_WIDTH'(start_mag);
      REG_ALIGN_CUR:     prdata = APB_DATA_WIDTH'($unsigned(align_cur));
      REG_ALIGN_TICKS:   prdata = APB_DATA_WIDTH'(align_ticks);
      REG_MOTION_EPS:    prdata = APB_DATA_WIDTH'(motion_eps);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow
  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_run  <= run;
      s1_pos  <= position_mode;
      s1_req  <= speed_request;
      s1_meas <= speed_measured;
    end
  end

  // ---------------------------------------------------------------- datapath
  logic signed [SPEED_WIDTH:0]     req_ext, meas_ext;
  logic [SPEED_WIDTH-1:0]          req_mag, meas_mag;
  logic                            low_req;
  logic                            enter_req;
  logic                            moving;
  logic                            near_stop;
  logic signed [CURRENT_WIDTH-1:0] signed_start;

  logic signed [ERR_W-1:0]         err;
  logic signed [PROD_W-1:0]        p_prod, i_prod;
  logic signed [PROD_W-1:0]        p_round, i_round;
  logic signed [P_W-1:0]           p_val;
  logic signed [I_W-1:0]           i_step;
  logic signed [SUM_W-1:0]         upper_ext, lower_ext, iq_lower_ext;
  logic signed [SUM_W-1:0]         integ_sum, integ_clamped;
  logic signed [SUM_W-1:0]         q_sum, q_raised, q_clamped;
  logic signed [CURRENT_WIDTH-1:0] integ_loop;
  logic signed [CURRENT_WIDTH-1:0] q_loop;
  logic signed [CURRENT_WIDTH:0]   q_ext;
  logic [CURRENT_WIDTH:0]          q_mag;
  logic signed [CURRENT_WIDTH-1:0] q_final;

  always_comb begin
    req_ext  = (SPEED_WIDTH+1)'(s1_req);
    meas_ext = (SPEED_WIDTH+1)'(s1_meas);
    req_mag  = SPEED_WIDTH'(s1_req[SPEED_WIDTH-1] ? -req_ext : req_ext);
    meas_mag = SPEED_WIDTH'(s1_meas[SPEED_WIDTH-1] ? -meas_ext : meas_ext);

    low_req   = ~s1_pos &&
                (LOW_W'(req_mag) * LOW_W'(LEAVE_MUL) < LOW_W'(LEAVE_LIMIT));
    enter_req = req_mag > SPEED_WIDTH'(ENTER_RAW);
    moving    = meas_mag > SPEED_WIDTH'(motion_eps);
    near_stop = (meas_mag < SPEED_WIDTH'(motion_eps)) &&
                (req_mag > SPEED_WIDTH'(BREAKAWAY_RAW));

    signed_start = s1_req[SPEED_WIDTH-1] ? -$signed(CURRENT_WIDTH'(start_mag))
                                         :  $signed(CURRENT_WIDTH'(start_mag));

    err    = ERR_W'(s1_req) - ERR_W'(s1_meas);
    p_prod = $signed({1'b0, prop_gain}) * err;
    i_prod = $signed({1'b0, integ_gain_dt}) * err;
    // round to nearest, ties up: add half then shift arithmetically
    p_round = p_prod + PROD_W'(1 << (P_SHIFT - 1));
    i_round = i_prod + PROD_W'(1 << (I_SHIFT - 1));
    p_val   = p_round[PROD_W-1:P_SHIFT];
    i_step  = i_round[PROD_W-1:I_SHIFT];

    upper_ext    = $signed(SUM_W'(iq_upper));
    lower_ext    = -upper_ext;
    iq_lower_ext = SUM_W'(iq_lower);

    integ_sum = SUM_W'(integrator) + SUM_W'(i_step);
    if (integ_sum < lower_ext) begin
      integ_clamped = lower_ext;
    end else if (integ_sum > upper_ext) begin
      integ_clamped = upper_ext;
    end else begin
      integ_clamped = integ_sum;
    end
    integ_loop = integ_clamped[CURRENT_WIDTH-1:0];

    // raise to the lower bound first, then cap at the upper bound
    q_sum    = SUM_W'(p_val) + SUM_W'(integ_loop);
    q_raised = (q_sum < iq_lower_ext) ? iq_lower_ext : q_sum;
    q_clamped = (q_raised > upper_ext) ? upper_ext : q_raised;
    q_loop   = q_clamped[CURRENT_WIDTH-1:0];

    q_ext = (CURRENT_WIDTH+1)'(q_loop);
    q_mag = q_loop[CURRENT_WIDTH-1] ? $unsigned(-q_ext) : $unsigned(q_ext);
    // breakaway: push at least the start current near standstill
    q_final = (near_stop && (q_mag < (CURRENT_WIDTH+1)'(start_mag))) ? signed_start
                                                                     : q_loop;
  end

  // ---------------------------------------------------------------- phase
  always_comb begin
    phase_next = phase;
    if (!s1_run) begin
      phase_next = PH_IDLE;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (s1_pos) begin
            phase_next = PH_LOOP;
          end else if (enter_req) begin
            phase_next = PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          if (low_req) begin
            phase_next = PH_IDLE;
          end else if (COUNT_WIDTH'(align_count + 1'b1) >= align_ticks) begin
            phase_next = PH_START;
          end
        end
        PH_START: begin
          if (low_req) begin
            phase_next = PH_IDLE;
          end else if (moving) begin
            phase_next = PH_LOOP;
          end
        end
        PH_LOOP: begin
          if (low_req) begin
            phase_next = PH_IDLE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    align_count_next = align_count;
    integrator_next  = integrator;
    iq_held_next     = iq_held;
    id_held_next     = id_held;
    if (!s1_run) begin
      iq_held_next    = '0;
      integrator_next = '0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          iq_held_next    = '0;
          integrator_next = '0;
        end
        PH_ALIGN: begin
          iq_held_next = '0;
          if (COUNT_WIDTH'(align_count + 1'b1) >= align_ticks) begin
            align_count_next = '0;
            id_held_next     = '0;
          end else begin
            align_count_next = COUNT_WIDTH'(align_count + 1'b1);
            id_held_next     = align_cur;
          end
        end
        PH_START: begin
          iq_held_next = signed_start;
          // hand the start current over to the integrator
          if (moving) begin
            integrator_next = signed_start;
          end
        end
        PH_LOOP: begin
          if (!low_req) begin
            integrator_next = integ_loop;
            iq_held_next    = q_final;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      align_count <= '0;
      integrator  <= '0;
      iq_held     <= '0;
      id_held     <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      align_count <= align_count_next;
      integrator  <= integrator_next;
      iq_held     <= iq_held_next;
      id_held     <= id_held_next;
    end
  end

  // state changes only when a result is loaded, so it doubles as the payload
  assign iq_request = iq_held;
  assign id_request = id_held;
  assign ctrl_phase = phase;

endmodule

@@ tb/tb.sv @@
module tb;
  import mspi_pkg::*;

  typedef struct packed {
    logic signed [CURRENT_WIDTH-1:0] iq;
    logic signed [CURRENT_WIDTH-1:0] id;
    phase_t                          phase;
  } current_cmd_t;

  typedef enum int {RX_FREE, RX_RANDOM, RX_COMB, RX_LONG} rx_mode_t;

  localparam longint SPEED_MAX = (longint'(1) << (SPEED_WIDTH - 1)) - 1;
  localparam longint SPEED_MIN = -(longint'(1) << (SPEED_WIDTH - 1));

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  logic                             run = 1'b0;
  logic                             position_mode = 1'b0;
  logic signed [SPEED_WIDTH-1:0]    speed_request = '0;
  logic signed [SPEED_WIDTH-1:0]    speed_measured = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  logic signed [CURRENT_WIDTH-1:0]  iq_request;
  logic signed [CURRENT_WIDTH-1:0]  id_request;
  logic [1:0]                       ctrl_phase;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0]        paddr = '0;
  logic [APB_DATA_WIDTH-1:0]        pwdata = '0;
  logic [APB_DATA_WIDTH-1:0]        prdata;
  logic                             pready;

  motor_speed_pi_startup_sequencer DUT (.*);

  always #2 clk = ~clk;

  // controller copy: state
  phase_t                          ctl_phase;
  logic [COUNT_WIDTH-1:0]          align_cnt;
  logic signed [CURRENT_WIDTH-1:0] integ_acc, iq_hold, id_hold;
  // controller copy: settings
  logic [GAIN_WIDTH-1:0]           kp_reg, ki_reg;
  logic [CURRENT_WIDTH-2:0]        iq_up_reg, start_reg;
  logic signed [CURRENT_WIDTH-1:0] iq_lo_reg, align_cur_reg;
  logic [COUNT_WIDTH-1:0]          ticks_reg;
  logic [SPEED_WIDTH-2:0]          eps_reg;

  current_cmd_t pending_cmds[$];
  int mismatches = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  rx_mode_t rx_mode = RX_FREE;
  int rx_period = 5;
  int rx_count = 0;
  int stall_left = 0;

  function automatic longint round_q8(longint prod, int sh);
    return (prod + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  function automatic longint sat_speed(longint v);
    if (v > SPEED_MAX) return SPEED_MAX;
    if (v < SPEED_MIN) return SPEED_MIN;
    return v;
  endfunction

  task automatic note_failure(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  // Advance the controller copy by one tick and queue the current command it yields.
  task automatic advance_controller(input logic run_i, input logic pos_i,
                                    input logic signed [SPEED_WIDTH-1:0] req_i,
                                    input logic signed [SPEED_WIDTH-1:0] meas_i);
    longint req, meas, areq, ameas, sstart, err, p, acc, q, up, lo;
    bit low_req;
    current_cmd_t cmd;
    req = req_i;
    meas = meas_i;
    areq = (req < 0) ? -req : req;
    ameas = (meas < 0) ? -meas : meas;
    up = longint'(iq_up_reg);
    lo = longint'(iq_lo_reg);
    low_req = !pos_i && (LEAVE_MUL * areq < LEAVE_LIMIT);
    sstart = (req < 0) ? -longint'(start_reg) : longint'(start_reg);
    if (!run_i) begin
      iq_hold = '0;
      integ_acc = '0;
      ctl_phase = PH_IDLE;
    end else begin
      case (ctl_phase)
        PH_IDLE: begin
          iq_hold = '0;
          integ_acc = '0;
          if (pos_i) ctl_phase = PH_LOOP;
          else if (areq > ENTER_RAW) ctl_phase = PH_ALIGN;
        end
        PH_ALIGN: begin
          id_hold = align_cur_reg;
          iq_hold = '0;
          align_cnt = align_cnt + 1'b1;
          if (align_cnt >= ticks_reg) begin
            align_cnt = '0;
            id_hold = '0;
            ctl_phase = PH_START;
          end
          if (low_req) ctl_phase = PH_IDLE;
        end
        PH_START: begin
          iq_hold = sstart[CURRENT_WIDTH-1:0];
          if (ameas > longint'(eps_reg)) begin
            integ_acc = sstart[CURRENT_WIDTH-1:0];
            ctl_phase = PH_LOOP;
          end
          if (low_req) ctl_phase = PH_IDLE;
        end
        PH_LOOP: begin
          // dropout leaves the held q request alone
          if (low_req) begin
            ctl_phase = PH_IDLE;
          end else begin
            err = req - meas;
            p = round_q8(longint'(kp_reg) * err, P_SHIFT);
            acc = longint'(integ_acc) + round_q8(longint'(ki_reg) * err, I_SHIFT);
            if (acc < -up) acc = -up;
            if (acc > up) acc = up;
            integ_acc = acc[CURRENT_WIDTH-1:0];
            q = p + acc;
            if (q < lo) q = lo;
            if (q > up) q = up;
            // breakaway floor near standstill
            if (ameas < longint'(eps_reg) && areq > BREAKAWAY_RAW &&
                ((q < 0) ? -q : q) < longint'(start_reg))
              q = sstart;
            iq_hold = q[CURRENT_WIDTH-1:0];
          end
        end
      endcase
    end
    cmd.iq = iq_hold;
    cmd.id = id_hold;
    cmd.phase = ctl_phase;
    pending_cmds.push_back(cmd);
  endtask

  task automatic store_setting(input logic [2:0] idx, input logic [APB_DATA_WIDTH-1:0] data);
    case (reg_index_t'(idx))
      REG_PROP_GAIN:     kp_reg = data[GAIN_WIDTH-1:0];
      REG_INTEG_GAIN_DT: ki_reg = data[GAIN_WIDTH-1:0];
      REG_IQ_UPPER:      iq_up_reg = data[CURRENT_WIDTH-2:0];
      REG_IQ_LOWER:      iq_lo_reg = data[CURRENT_WIDTH-1:0];
      REG_START_MAG:     start_reg = data[CURRENT_WIDTH-2:0];
      REG_ALIGN_CUR:     align_cur_reg = data[CURRENT_WIDTH-1:0];
      REG_ALIGN_TICKS:   ticks_reg = data[COUNT_WIDTH-1:0];
      REG_MOTION_EPS:    eps_reg = data[SPEED_WIDTH-2:0];
    endcase
  endtask

  // Check results first, then take in this edge's tick transfer and register write.
  always @(posedge clk) begin
    current_cmd_t want;
    if (rst) begin
      ctl_phase = PH_IDLE;
      align_cnt = '0;
      integ_acc = '0;
      iq_hold = '0;
      id_hold = '0;
      kp_reg = '0;
      ki_reg = '0;
      iq_up_reg = '0;
      iq_lo_reg = '0;
      start_reg = '0;
      align_cur_reg = '0;
      ticks_reg = '0;
      eps_reg = '0;
      pending_cmds.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_cmds.size() == 0) begin
          note_failure($sformatf("result with no tick pending: iq %0d id %0d phase %0d",
                                 iq_request, id_request, ctrl_phase));
        end else begin
          want = pending_cmds.pop_front();
          if (iq_request !== want.iq)
            note_failure($sformatf("iq_request expected %0d, got %0d", want.iq, iq_request));
          if (id_request !== want.id)
            note_failure($sformatf("id_request expected %0d, got %0d", want.id, id_request));
          if (ctrl_phase !== want.phase)
            note_failure($sformatf("ctrl_phase expected %0d, got %0d",
                                   want.phase, ctrl_phase));
        end
      end
      if (in_valid && in_ready)
        advance_controller(run, position_mode, speed_request, speed_measured);
      if (psel && penable && pwrite && pready)
        store_setting(paddr[4:2], pwdata);
    end
  end

  always @(negedge clk) begin
    rx_count++;
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
      RX_COMB:   out_ready <= ((rx_count % rx_period) < rx_period - 2);
      RX_LONG: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          stall_left = $urandom_range(4, 16);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  task automatic send_tick(input bit r, input bit pm, input longint sr, input longint sm);
    int gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    run <= r;
    position_mode <= pm;
    speed_request <= sr[SPEED_WIDTH-1:0];
    speed_measured <= sm[SPEED_WIDTH-1:0];
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid and hold until every pending command has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [APB_DATA_WIDTH-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_settings(int kp, int ki, int up, int lo, int st, int aid,
                                  int ticks, int eps);
    settle();
    cfg_write(REG_PROP_GAIN, kp & 32'hFFFF);
    cfg_write(REG_INTEG_GAIN_DT, ki & 32'hFFFF);
    cfg_write(REG_IQ_UPPER, up & 32'h7FFF);
    cfg_write(REG_IQ_LOWER, lo & 32'hFFFF);
    cfg_write(REG_START_MAG, st & 32'h7FFF);
    cfg_write(REG_ALIGN_CUR, aid & 32'hFFFF);
    cfg_write(REG_ALIGN_TICKS, ticks & 32'hFFFF);
    cfg_write(REG_MOTION_EPS, eps & 32'h7FFFFF);
  endtask

  task automatic test_startup_sequence();
    program_settings(4096, 655, 2560, -2560, 512, 768, 2, 256);
    rx_mode = RX_RANDOM;
    gaps_on = 1'b1;
    send_tick(1'b0, 1'b0, SPEED_MAX, SPEED_MIN);
    send_tick(1'b1, 1'b0, 128, 0);
    send_tick(1'b1, 1'b0, 129, 0);
    send_tick(1'b1, 1'b0, 129, 0);
    send_tick(1'b1, 1'b0, 129, 0);
    send_tick(1'b1, 1'b0, -2000, 0);
    send_tick(1'b1, 1'b0, -2000, 256);
    send_tick(1'b1, 1'b0, -2000, -257);
    send_tick(1'b1, 1'b0, SPEED_MAX, SPEED_MIN);
    send_tick(1'b1, 1'b0, SPEED_MIN, SPEED_MAX);
    send_tick(1'b1, 1'b0, 52, 0);
    send_tick(1'b1, 1'b0, -51, 0);
  endtask

  task automatic test_breakaway_and_hold();
    program_settings(0, 0, 1000, -1000, 700, -32768, 0, 8388607);
    rx_mode = RX_FREE;
    gaps_on = 1'b0;
    send_tick(1'b0, 1'b1, 0, 0);
    send_tick(1'b1, 1'b1, 0, 0);
    send_tick(1'b1, 1'b0, 2000, 0);
    send_tick(1'b1, 1'b1, 10, 0);
    send_tick(1'b1, 1'b0, -2000, 5);
    send_tick(1'b1, 1'b0, 51, 0);
    send_tick(1'b1, 1'b0, SPEED_MIN, 0);
    send_tick(1'b1, 1'b0, SPEED_MIN, 0);
    send_tick(1'b1, 1'b0, SPEED_MIN, SPEED_MIN);
  endtask

  task automatic test_crossed_bounds();
    program_settings(65535, 65535, 100, 32767, 0, 32767, 5, 0);
    rx_mode = RX_LONG;
    gaps_on = 1'b1;
    send_tick(1'b0, 1'b0, 0, 0);
    send_tick(1'b1, 1'b1, 0, 0);
    send_tick(1'b1, 1'b0, SPEED_MAX, SPEED_MIN);
    send_tick(1'b1, 1'b0, -SPEED_MAX, SPEED_MAX);
    send_tick(1'b0, 1'b0, 200, 0);
    send_tick(1'b1, 1'b0, 200, 0);
    send_tick(1'b1, 1'b0, 200, 0);
    send_tick(1'b1, 1'b0, 0, 0);
  endtask

  // Mostly full startup runs (align, torque start, handoff, closed loop) with random
  // content; the rest is raw noise, position hold and early dropouts.
  task automatic run_sessions(int n);
    int stop_at, len, i, choice, hold;
    longint tgt, m, eps_v, small_cap, mv, req_now;
    bit neg, early;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      choice = $urandom_range(0, 19);
      eps_v = longint'(eps_reg);
      small_cap = (eps_v > 2000) ? 2000 : eps_v;
      if (choice < 3) begin
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++)
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    longint'($urandom), longint'($urandom));
      end else if (choice < 6) begin
        len = $urandom_range(4, 30);
        for (i = 0; i < len; i++) begin
          tgt = longint'($urandom_range(0, 4000)) - 2000;
          m = tgt + longint'($urandom_range(0, 600)) - 300;
          send_tick(1'b1, ($urandom_range(0, 9) != 0), sat_speed(tgt), sat_speed(m));
        end
      end else begin
        neg = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 9))
          0: tgt = longint'($urandom_range(129, 1280));
          1: tgt = SPEED_MAX - longint'($urandom_range(0, 100000));
          default: tgt = longint'($urandom_range(1281, 60000));
        endcase
        if (neg) tgt = -tgt;
        if ($urandom_range(0, 1)) send_tick(1'b0, 1'b0, sat_speed(tgt), 0);
        hold = ((ticks_reg > 30) ? 30 : int'(ticks_reg)) + $urandom_range(1, 4);
        for (i = 0; i < hold; i++) begin
          m = longint'($urandom_range(0, small_cap * 2)) - small_cap;
          send_tick(1'b1, 1'b0, sat_speed(tgt), sat_speed(m));
        end
        early = ($urandom_range(0, 7) == 0);
        len = early ? 0 : $urandom_range(3, 40);
        m = 0;
        for (i = 0; i < len; i++) begin
          if (i == 0) begin
            mv = eps_v + 1 + longint'($urandom_range(0, 500));
            if (mv > SPEED_MAX) m = SPEED_MIN;
            else m = neg ? -mv : mv;
          end else if ($urandom_range(0, 4) == 0) begin
            m = longint'($urandom_range(0, small_cap * 2)) - small_cap;
          end else begin
            m = tgt * i / len + longint'($urandom_range(0, 800)) - 400;
          end
          req_now = ($urandom_range(0, 9) == 0) ?
                    tgt + longint'($urandom_range(0, 4000)) - 2000 : tgt;
          send_tick(1'b1, 1'b0, sat_speed(req_now), sat_speed(m));
        end
        case ($urandom_range(0, 2))
          0: send_tick(1'b1, 1'b0, longint'($urandom_range(0, 102)) - 51, sat_speed(m));
          1: send_tick(1'b0, 1'($urandom_range(0, 1)), sat_speed(tgt), sat_speed(m));
          default: ;
        endcase
      end
    end
  endtask

  task automatic test_random_phases();
    int p, up, lo;
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          up = $urandom_range(256, 8000);
          program_settings($urandom_range(0, 16384), $urandom_range(0, 4000), up, -up,
                           $urandom_range(0, up), $urandom, $urandom_range(0, 12),
                           $urandom_range(0, 1500));
          rx_mode = RX_RANDOM;
          gaps_on = 1'b1;
        end
        1: begin
          program_settings(65535, 65535, 32767, -32768, 32767, -32768, 65535, 8388607);
          rx_mode = RX_LONG;
          gaps_on = 1'b1;
        end
        2: begin
          program_settings(0, 0, 0, 0, 0, 0, 0, 0);
          rx_period = $urandom_range(3, 9);
          rx_mode = RX_COMB;
          gaps_on = 1'b1;
        end
        3: begin
          // weak gains so the breakaway floor takes over
          up = $urandom_range(1000, 32767);
          program_settings($urandom_range(0, 300), $urandom_range(0, 300), up,
                           -int'($urandom_range(0, 32768)), $urandom_range(200, up),
                           $urandom, $urandom_range(0, 6), $urandom_range(500, 4000));
          rx_mode = RX_FREE;
          gaps_on = 1'b0;
        end
        4: begin
          up = $urandom_range(0, 500);
          lo = up + 1 + int'($urandom_range(0, 2000));
          program_settings($urandom, $urandom, up, lo, $urandom_range(0, 32767), $urandom,
                           $urandom_range(0, 8), $urandom_range(0, 1000));
          rx_mode = RX_RANDOM;
          gaps_on = 1'b1;
        end
        default: begin
          up = $urandom_range(256, 20000);
          lo = -up + int'($urandom_range(0, up));
          program_settings($urandom_range(0, 65535), $urandom_range(0, 65535), up, lo,
                           $urandom_range(0, up), $urandom, $urandom_range(0, 20),
                           $urandom_range(0, 8388607 >> 8));
          rx_mode = RX_LONG;
          gaps_on = 1'b1;
        end
      endcase
      if (p == 5) begin
        run_sessions(140);
        // hold off the sender until every pending command has come back
        settle();
        run_sessions(140);
      end else begin
        run_sessions(280);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_startup_sequence();
    test_breakaway_and_hold();
    test_crossed_bounds();
    test_random_phases();
    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("** motor_speed_pi_startup_sequencer: PASSED **");
    end else begin
      $display("** motor_speed_pi_startup_sequencer: FAILED **");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("** motor_speed_pi_startup_sequencer: FAILED **");
    $finish;
  end

endmodule
